FILE: design/mmvpg_pkg.sv
`default_nettype none
package mmvpg_pkg;

  localparam int CFG_W = 10;
  localparam int MODE_W = 4;
  localparam int NUM_MODES = 9;

  localparam logic [MODE_W-1:0] MODE_QUIET  = 4'd0;
  localparam logic [MODE_W-1:0] MODE_SINE   = 4'd1;
  localparam logic [MODE_W-1:0] MODE_SQUARE = 4'd2;
  localparam logic [MODE_W-1:0] MODE_TRI    = 4'd3;
  localparam logic [MODE_W-1:0] MODE_NOISE  = 4'd4;
  localparam logic [MODE_W-1:0] MODE_SAW    = 4'd5;
  localparam logic [MODE_W-1:0] MODE_RSAW   = 4'd6;
  localparam logic [MODE_W-1:0] MODE_SOS    = 4'd7;
  localparam logic [MODE_W-1:0] MODE_JITTER = 4'd8;

  localparam logic REG_KEY_HOLDOFF = 1'b0;
  localparam logic REG_TICKS_PER_SEC = 1'b1;

  typedef enum logic [3:0] {
    S_IDLE,
    S_UPDATE,
    S_MODST,
    S_MOD,
    S_FRAC,
    S_WAVE,
    S_SPROD,
    S_SLD,
    S_SDIV,
    S_SFIN,
    S_DMUL,
    S_DLD,
    S_DDIV,
    S_DONE
  } state_t;

  typedef enum logic [2:0] {
    DIV_NONE,
    DIV_MOD,
    DIV_FRAC,
    DIV_SINE
  } div_cmd_t;

endpackage
`default_nettype wire

FILE: design/multi_mode_vibration_pattern_generator_core.sv
// Vibration pattern generator: each accepted tick item carries button levels and
// random draws, and yields one result item with the motor duty, the active mode,
// the power level and a mode-change flag. The next tick is accepted only once the
// result of the previous one has been registered; sine mode adds a sine step on
// the divider. One shared restoring divider retires one quotient bit per cycle
// and serves the phase modulo, the phase fraction and the sine evaluation in
// turn; the duty scaling uses a constant reciprocal multiply. A result that has
// not been taken holds the core in its last step.
`default_nettype none
module multi_mode_vibration_pattern_generator_core
  import mmvpg_pkg::*;
#(
  parameter int SINE_TABLE_DEPTH = 256,
  parameter int FRACTION_BITS = 16,
  parameter int LEVEL_STEPS = 10
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              cfg_write,
  input  wire logic              cfg_index,
  input  wire logic [CFG_W-1:0]  cfg_data,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire logic              next_button,
  input  wire logic              up_button,
  input  wire logic              down_button,
  input  wire logic [3:0]        mode_offset,
  input  wire logic              noise_bit,
  input  wire logic [15:0]       new_threshold,
  input  wire logic [15:0]       jitter_threshold,
  input  wire logic [5:0]        duration_seconds,
  input  wire logic [3:0]        period_seconds,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output logic [7:0]             duty,
  output logic [MODE_W-1:0]      active_mode,
  output logic [3:0]             power_level,
  output logic                   mode_changed
);

  localparam int FB = FRACTION_BITS;
  localparam int DEPTH = SINE_TABLE_DEPTH;
  localparam int ONE_W = FB + 1;
  localparam int AW = $clog2(DEPTH + 1);
  localparam int IDXW = $clog2(DEPTH);
  localparam int IPW = FB + AW;
  localparam int PRODW = 2 * AW;
  localparam int PMW = FB + 5;

  localparam int MOD_NB = 17;
  localparam int FRAC_NB = 15 + FB;
  localparam int SNUM_NB = PRODW + 4 + FB;
  localparam int W2 = (FRAC_NB > MOD_NB) ? FRAC_NB : MOD_NB;
  localparam int DIV_W = (SNUM_NB > W2) ? SNUM_NB : W2;

  localparam int SDEN = 5 * DEPTH * DEPTH;
  localparam int SDENW = $clog2(SDEN + 1);
  localparam int DVW = (SDENW > 15) ? SDENW : 15;
  localparam int CNTW = $clog2(DIV_W + 1);

  // Duty scaling: floor(y / LEVEL_STEPS) as (y * RM) >> RK, exact for every y here.
  localparam int YW = $clog2(255 * LEVEL_STEPS + 1);
  localparam int RK = 20;
  localparam int RM = ((1 << RK) + LEVEL_STEPS - 1) / LEVEL_STEPS;
  localparam int RPW = YW + RK;

  localparam logic [ONE_W-1:0] ONE_V = {1'b1, {FB{1'b0}}};
  localparam logic [AW-1:0] DEPTH_V = AW'(DEPTH);
  localparam logic [DVW-1:0] SDEN_V = DVW'(SDEN);
  localparam logic [RPW-1:0] RM_V = RPW'(RM);
  localparam logic [3:0] LEVEL_MAX = 4'(LEVEL_STEPS);

  state_t state, state_next;
  div_cmd_t div_cmd;

  // Configuration and tick state.
  logic [9:0] key_holdoff_ticks, ticks_per_second;
  logic [MODE_W-1:0] mode_reg;
  logic start_pending, jitter_first, changed;
  logic [16:0] elapsed_ticks;
  logic [14:0] period_ticks;
  logic [15:0] duration_ticks, threshold_reg;
  logic [ONE_W-1:0] power_reg;
  logic [3:0] level_reg;
  logic [9:0] key_counter;

  // Latched input item.
  logic b_next, b_up, b_down, b_noise;
  logic [3:0] b_offset, b_period;
  logic [15:0] b_thr, b_jthr;
  logic [5:0] b_dur;

  // Shared divider.
  logic [DIV_W-1:0] div_n, div_q;
  logic [DVW-1:0] div_r, div_d;
  logic [CNTW-1:0] div_cnt;
  logic [DVW:0] div_trial;
  logic div_ge;

  // Sine and duty intermediates.
  logic [AW-1:0] sine_a;
  logic sine_upper;
  logic [PRODW-1:0] sine_prod;
  logic [PMW-1:0] pm;
  logic [PMW+7:0] pm_x255;
  logic [YW-1:0] duty_y;
  logic [RPW-1:0] duty_prod;
  logic [7:0] duty_v;

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE:   if (in_valid) state_next = S_UPDATE;
      S_UPDATE: state_next = S_MODST;
      S_MODST:  state_next = S_MOD;
      S_MOD:    if (div_cnt == '0) state_next = S_FRAC;
      S_FRAC:   if (div_cnt == '0) state_next = S_WAVE;
      S_WAVE:   state_next = (mode_reg == MODE_SINE) ? S_SPROD : S_DMUL;
      S_SPROD:  state_next = S_SLD;
      S_SLD:    state_next = S_SDIV;
      S_SDIV:   if (div_cnt == '0) state_next = S_SFIN;
      S_SFIN:   state_next = S_DMUL;
      S_DMUL:   state_next = S_DLD;
      S_DLD:    state_next = S_DDIV;
      S_DDIV:   state_next = S_DONE;
      S_DONE:   if (!out_valid || out_ready) state_next = S_IDLE;
      default:  state_next = S_IDLE;
    endcase
  end

  always_comb begin
    in_ready = 1'b0;
    div_cmd = DIV_NONE;
    unique case (state)
      S_IDLE:  in_ready = 1'b1;
      S_MODST: div_cmd = DIV_MOD;
      S_MOD:   if (div_cnt == '0) div_cmd = DIV_FRAC;
      S_SLD:   div_cmd = DIV_SINE;
      default: div_cmd = DIV_NONE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else state <= state_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      key_holdoff_ticks <= 10'd50;
      ticks_per_second <= 10'd100;
    end else if (cfg_write) begin
      if (cfg_index == REG_KEY_HOLDOFF) key_holdoff_ticks <= cfg_data;
      if (cfg_index == REG_TICKS_PER_SEC) ticks_per_second <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      b_next <= next_button;
      b_up <= up_button;
      b_down <= down_button;
      b_offset <= mode_offset;
      b_noise <= noise_bit;
      b_thr <= new_threshold;
      b_jthr <= jitter_threshold;
      b_dur <= duration_seconds;
      b_period <= period_seconds;
    end
  end

  // Tick bookkeeping: buttons, mode change and level.
  logic [9:0] kc;
  logic sample, s_next, s_up, s_down, chg;
  logic [3:0] off;
  logic [4:0] msum;
  logic [MODE_W-1:0] mode_new;
  logic [15:0] dur_prod;
  logic [13:0] per_prod;
  logic [15:0] per_x;

  always_comb begin
    kc = (key_counter < 10'd1023) ? key_counter + 10'd1 : key_counter;
    sample = (kc >= key_holdoff_ticks);
    s_next = sample & b_next;
    s_up = sample & b_up;
    s_down = sample & b_down;
    chg = start_pending || s_next || (elapsed_ticks >= {1'b0, duration_ticks});
    off = (b_offset >= 4'(NUM_MODES)) ? b_offset - 4'(NUM_MODES) : b_offset;
    if (off == 4'd0) off = 4'd1;
    msum = {1'b0, mode_reg} + {1'b0, off};
    if (msum >= 5'(NUM_MODES)) msum = msum - 5'(NUM_MODES);
    mode_new = chg ? msum[MODE_W-1:0] : mode_reg;
    dur_prod = 16'(b_dur) * 16'(ticks_per_second);
    per_prod = 14'(b_period) * 14'(ticks_per_second);
    per_x = (mode_new == MODE_JITTER) ? 16'(per_prod) * 16'd3 : 16'(per_prod);
    if (per_x > 16'd32767) per_x = 16'd32767;
    if (per_x == 16'd0) per_x = 16'd1;
  end

  // Wave shaping from the phase fraction.
  logic [FB-1:0] frac;
  logic thr_hit;
  logic [ONE_W:0] tri_v;
  logic [4:0] slot;
  logic sos;
  logic [IPW-1:0] idx_full;
  logic [IDXW-1:0] idx;
  logic [AW:0] q_ext, a_ext;
  logic up_half;

  always_comb begin
    frac = div_q[FB-1:0];
    thr_hit = ({frac, 16'h0000} >= {threshold_reg, {FB{1'b0}}});
    if ({1'b0, frac} <= (ONE_V >> 1)) tri_v = {1'b0, frac, 1'b0};
    else tri_v = {ONE_V, 1'b0} - {1'b0, frac, 1'b0};
    slot = frac[FB-1 -: 5];
    sos = (slot == 5'd0) || (slot == 5'd2) || (slot == 5'd4) ||
          (slot >= 5'd8 && slot < 5'd13) || (slot >= 5'd16 && slot < 5'd21) ||
          (slot >= 5'd24 && slot < 5'd29);
    idx_full = (IPW'(frac) * IPW'(DEPTH)) >> FB;
    idx = idx_full[IDXW-1:0];
    q_ext = (AW+1)'({idx, 1'b0});
    up_half = q_ext < (AW+1)'(DEPTH);
    a_ext = up_half ? q_ext : q_ext - (AW+1)'(DEPTH);
    if (a_ext > (AW+1)'(DEPTH)) a_ext = (AW+1)'(DEPTH);
  end

  // Sine result and duty scaling.
  logic [ONE_W-1:0] s_cap, p_cap;
  logic [ONE_W:0] s_pow;

  always_comb begin
    s_cap = (div_q > DIV_W'(ONE_V)) ? ONE_V : div_q[ONE_W-1:0];
    s_pow = sine_upper ? ({1'b0, ONE_V} + {1'b0, s_cap}) >> 1
                       : ({1'b0, ONE_V} - {1'b0, s_cap}) >> 1;
    p_cap = (power_reg > ONE_V) ? ONE_V : power_reg;
    pm_x255 = ((PMW+8)'(pm) << 8) - (PMW+8)'(pm);
    duty_prod = RPW'(duty_y) * RM_V;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode_reg <= MODE_QUIET;
      start_pending <= 1'b1;
      elapsed_ticks <= '0;
      period_ticks <= 15'd100;
      duration_ticks <= 16'd1000;
      threshold_reg <= 16'd32768;
      jitter_first <= 1'b1;
      power_reg <= '0;
      level_reg <= LEVEL_MAX;
      key_counter <= '0;
      changed <= 1'b0;
    end else begin
      unique case (state)
        S_UPDATE: begin
          key_counter <= sample ? 10'd0 : kc;
          mode_reg <= mode_new;
          changed <= chg;
          if (s_up) begin
            if (level_reg < LEVEL_MAX) level_reg <= level_reg + 4'd1;
          end else if (s_down) begin
            if (level_reg > 4'd0) level_reg <= level_reg - 4'd1;
          end
          if (chg) begin
            threshold_reg <= b_thr;
            duration_ticks <= dur_prod;
            period_ticks <= per_x[14:0];
            elapsed_ticks <= '0;
            start_pending <= 1'b0;
          end
        end
        S_WAVE: begin
          elapsed_ticks <= (elapsed_ticks < 17'h1FFFF) ? elapsed_ticks + 17'd1
                                                       : elapsed_ticks;
          priority case (mode_reg)
            MODE_SINE:   power_reg <= power_reg;
            MODE_SQUARE: power_reg <= thr_hit ? ONE_V : '0;
            MODE_TRI:    power_reg <= tri_v[ONE_W-1:0];
            MODE_NOISE:  if (frac == '0) power_reg <= b_noise ? ONE_V : '0;
            MODE_SAW:    power_reg <= {1'b0, frac};
            MODE_RSAW:   power_reg <= ONE_V - {1'b0, frac};
            MODE_SOS:    power_reg <= sos ? ONE_V : '0;
            MODE_JITTER: begin
              if (jitter_first) begin
                if (thr_hit) begin
                  jitter_first <= 1'b0;
                  power_reg <= ONE_V;
                  threshold_reg <= b_jthr;
                end else begin
                  power_reg <= '0;
                end
              end else if (frac == '0) begin
                jitter_first <= 1'b1;
              end
            end
            default:     power_reg <= '0;
          endcase
        end
        S_SFIN: power_reg <= s_pow[ONE_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_WAVE) begin
      sine_a <= a_ext[AW-1:0];
      sine_upper <= up_half;
    end
    if (state == S_SPROD) sine_prod <= PRODW'(sine_a) * PRODW'(DEPTH_V - sine_a);
    if (state == S_DMUL) pm <= PMW'(p_cap) * PMW'(level_reg);
    if (state == S_DLD) duty_y <= YW'(pm_x255 >> FB);
    if (state == S_DDIV) begin
      duty_v <= ((duty_prod >> RK) > RPW'(255)) ? 8'd255 : duty_prod[RK +: 8];
    end
  end

  // Restoring divider, one quotient bit per cycle.
  always_comb begin
    div_trial = {div_r, div_n[DIV_W-1]};
    div_ge = (div_trial >= {1'b0, div_d});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      div_cnt <= '0;
    end else begin
      unique case (div_cmd)
        DIV_MOD: begin
          div_n <= DIV_W'(elapsed_ticks) << (DIV_W - MOD_NB);
          div_d <= DVW'(period_ticks);
          div_cnt <= CNTW'(MOD_NB);
        end
        DIV_FRAC: begin
          div_n <= DIV_W'(FRAC_NB'(div_r[14:0]) << FB) << (DIV_W - FRAC_NB);
          div_cnt <= CNTW'(FRAC_NB);
        end
        DIV_SINE: begin
          div_n <= DIV_W'(SNUM_NB'(sine_prod) << (FB + 4)) << (DIV_W - SNUM_NB);
          div_d <= SDEN_V - (DVW'(sine_prod) << 2);
          div_cnt <= CNTW'(SNUM_NB);
        end
        default: begin
          if (div_cnt != '0) begin
            div_n <= div_n << 1;
            div_q <= {div_q[DIV_W-2:0], div_ge};
            div_r <= div_ge ? DVW'(div_trial - {1'b0, div_d}) : div_trial[DVW-1:0];
            div_cnt <= div_cnt - CNTW'(1);
          end
        end
      endcase
      if (div_cmd != DIV_NONE) begin
        div_r <= '0;
        div_q <= '0;
      end
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == S_DONE && (!out_valid || out_ready)) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_DONE && (!out_valid || out_ready)) begin
      duty <= duty_v;
      active_mode <= mode_reg;
      power_level <= level_reg;
      mode_changed <= changed;
    end
  end

endmodule
`default_nettype wire

FILE: dv/tb.sv
`timescale 1ns / 100ps
`default_nettype none
module tb;
  import mmvpg_pkg::*;

  localparam int ONE = 65536;
  localparam int LEVELS = 10;
  localparam int TABLE_D = 256;
  localparam int STALL_LIMIT = 20000;

  typedef struct packed {
    logic       nxt;
    logic       up;
    logic       down;
    logic [3:0] offset;
    logic       noise;
    logic [15:0] thr;
    logic [15:0] jthr;
    logic [5:0] dur_s;
    logic [3:0] per_s;
  } tick_t;

  typedef struct packed {
    logic [7:0] duty;
    logic [3:0] mode;
    logic [3:0] level;
    logic       changed;
  } motor_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_write = 1'b0;
  logic cfg_index = 1'b0;
  logic [CFG_W-1:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_ready;
  tick_t tick_d = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  motor_t got;

  multi_mode_vibration_pattern_generator_core dut (
    .clk(clk), .rst(rst),
    .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_ready(in_ready),
    .next_button(tick_d.nxt), .up_button(tick_d.up), .down_button(tick_d.down),
    .mode_offset(tick_d.offset), .noise_bit(tick_d.noise),
    .new_threshold(tick_d.thr), .jitter_threshold(tick_d.jthr),
    .duration_seconds(tick_d.dur_s), .period_seconds(tick_d.per_s),
    .out_valid(out_valid), .out_ready(out_ready),
    .duty(got.duty), .active_mode(got.mode), .power_level(got.level),
    .mode_changed(got.changed)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Predictor state.
  int unsigned holdoff, tps;
  int unsigned cur_mode, elapsed, period, duration, threshold, level, keys;
  logic pending, jit_armed;
  longint unsigned power;
  motor_t duty_q[$];
  int errors = 0;
  int idle_cycles = 0;

  function automatic longint unsigned sine_value(longint unsigned frac);
    longint unsigned idx, q, a, prod, s;
    logic upper;
    idx = (frac * TABLE_D) >> 16;
    q = 2 * idx;
    upper = q < TABLE_D;
    a = upper ? q : q - TABLE_D;
    if (a > TABLE_D) a = TABLE_D;
    prod = a * (TABLE_D - a);
    s = ((16 * prod) << 16) / (5 * TABLE_D * TABLE_D - 4 * prod);
    if (s > ONE) s = ONE;
    return upper ? (ONE + s) / 2 : (ONE - s) / 2;
  endfunction

  function automatic logic sos_lit(longint unsigned frac);
    longint unsigned slot;
    slot = (frac * 32) >> 16;
    return slot == 0 || slot == 2 || slot == 4 || (slot >= 8 && slot < 13) ||
           (slot >= 16 && slot < 21) || (slot >= 24 && slot < 29);
  endfunction

  task automatic reset_model();
    holdoff = 50; tps = 100; cur_mode = 0; pending = 1'b1; elapsed = 0;
    period = 100; duration = 1000; threshold = 32768; jit_armed = 1'b1;
    power = 0; level = LEVELS; keys = 0;
  endtask

  task automatic predict_duty(tick_t t);
    logic nx, u, dn, chg;
    int unsigned e, off, per, dur;
    longint unsigned frac, thr_full, p;
    motor_t r;
    nx = 0; u = 0; dn = 0; chg = 0;
    e = elapsed;
    if (keys < 1023) keys++;
    if (keys >= holdoff) begin
      nx = t.nxt; u = t.up; dn = t.down; keys = 0;
    end
    if (pending || nx || e >= duration) begin
      off = t.offset % NUM_MODES;
      if (off == 0) off = 1;
      cur_mode = (cur_mode + off) % NUM_MODES;
      chg = 1;
    end
    if (u) begin
      if (level < LEVELS) level++;
    end else if (dn) begin
      if (level > 0) level--;
    end
    if (chg) begin
      threshold = t.thr;
      dur = t.dur_s * tps;
      duration = dur > 65535 ? 65535 : dur;
      per = t.per_s * tps;
      if (cur_mode == MODE_JITTER) per *= 3;
      if (per > 32767) per = 32767;
      if (per == 0) per = 1;
      period = per;
      e = 0;
      pending = 0;
    end
    frac = (longint'(e % period) << 16) / period;
    thr_full = longint'(threshold) << 16;
    case (cur_mode)
      MODE_SINE: power = sine_value(frac);
      MODE_SQUARE: power = (frac << 16) >= thr_full ? ONE : 0;
      MODE_TRI: power = frac <= ONE / 2 ? 2 * frac : 2 * ONE - 2 * frac;
      MODE_NOISE: if (frac == 0) power = t.noise ? ONE : 0;
      MODE_SAW: power = frac;
      MODE_RSAW: power = ONE - frac;
      MODE_SOS: power = sos_lit(frac) ? ONE : 0;
      MODE_JITTER: begin
        if (jit_armed) begin
          power = 0;
          if ((frac << 16) >= thr_full) begin
            jit_armed = 0;
            power = ONE;
            threshold = t.jthr;
          end
        end else if (frac == 0) begin
          jit_armed = 1;
        end
      end
      default: power = 0;
    endcase
    elapsed = e < 131071 ? e + 1 : 131071;
    p = power > ONE ? ONE : power;
    p = (p * level * 255) / (longint'(ONE) * LEVELS);
    r.duty = p > 255 ? 8'd255 : p[7:0];
    r.mode = cur_mode[3:0];
    r.level = level[3:0];
    r.changed = chg;
    duty_q.push_back(r);
  endtask

  task automatic report_mismatch(string what, int unsigned exp_v, int unsigned got_v);
    errors++;
    $display("tb: mismatch %s expected %0d got %0d", what, exp_v, got_v);
  endtask

  function automatic int unsigned rand_gap();
    int unsigned k;
    k = $urandom_range(0, 99);
    if (k < 40) return 0;
    if (k < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  logic gaps_on = 1'b1;

  // Valid stays high after an accepted item only when the next item follows at
  // the same falling edge; otherwise it drops before the gap.
  task automatic send_tick(tick_t t);
    int unsigned g;
    g = gaps_on ? rand_gap() : 0;
    if (g > 0) begin
      in_valid <= 1'b0;
      repeat (g) @(negedge clk);
    end
    tick_d <= t;
    in_valid <= 1'b1;
    predict_duty(t);
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
  endtask

  // Result side: random stalls, compare at each accepted item.
  always @(posedge clk) begin
    motor_t w;
    if (!rst && out_valid && out_ready) begin
      if (duty_q.size() == 0) begin
        report_mismatch("unexpected item", 0, 1);
      end else begin
        w = duty_q.pop_front();
        if (w.duty !== got.duty) report_mismatch("duty", w.duty, got.duty);
        if (w.mode !== got.mode) report_mismatch("active_mode", w.mode, got.mode);
        if (w.level !== got.level) report_mismatch("power_level", w.level, got.level);
        if (w.changed !== got.changed)
          report_mismatch("mode_changed", w.changed, got.changed);
      end
    end
  end

  int unsigned stall_left = 0;
  always @(negedge clk) begin
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_ready <= 1'b0;
    end else if (gaps_on && $urandom_range(0, 3) == 0) begin
      stall_left <= rand_gap();
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("tb: FAIL");
      $finish;
    end
  end

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (duty_q.size() != 0) @(negedge clk);
    repeat (200) @(negedge clk);
  endtask

  task automatic write_reg(logic idx, int unsigned val);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val[CFG_W-1:0];
    if (idx == REG_KEY_HOLDOFF) holdoff = val; else tps = val;
    @(negedge clk);
    cfg_write <= 1'b0;
  endtask

  function automatic tick_t rand_tick(int unsigned press_pct);
    tick_t t;
    t.nxt = $urandom_range(0, 99) < press_pct;
    t.up = $urandom_range(0, 99) < press_pct;
    t.down = $urandom_range(0, 99) < press_pct;
    t.offset = 4'($urandom_range(0, 15));
    t.noise = 1'($urandom_range(0, 1));
    t.thr = 16'($urandom());
    t.jthr = 16'($urandom());
    t.dur_s = 6'($urandom_range(0, 63));
    t.per_s = 4'($urandom_range(0, 15));
    return t;
  endfunction

  // Extremes of every field, plus zero offset, zero duration and period.
  task automatic test_directed();
    tick_t t;
    for (int i = 0; i < 24; i++) begin
      t = '0;
      t.offset = 4'(i % 16);
      t.dur_s = (i % 3 == 0) ? 6'd63 : (i % 3 == 1) ? 6'd0 : 6'd1;
      t.per_s = (i % 2) ? 4'd15 : 4'd0;
      t.thr = (i % 2) ? 16'hFFFF : 16'h0000;
      t.jthr = (i % 2) ? 16'h0000 : 16'hFFFF;
      t.noise = i[0];
      t.nxt = i[1];
      t.up = (i >= 12);
      t.down = (i < 12) || i[2];
      send_tick(t);
    end
  endtask

  // Short holdoff and small tick rate so modes cycle quickly.
  task automatic test_fast_modes();
    write_reg(REG_KEY_HOLDOFF, 0);
    write_reg(REG_TICKS_PER_SEC, 1);
    for (int i = 0; i < 200; i++) send_tick(rand_tick(15));
  endtask

  task automatic test_long_periods();
    tick_t t;
    write_reg(REG_KEY_HOLDOFF, 1023);
    write_reg(REG_TICKS_PER_SEC, 1000);
    for (int i = 0; i < 60; i++) send_tick(rand_tick(50));
    // Pause until the block has handed back every item.
    wait_drained();
    write_reg(REG_TICKS_PER_SEC, 3);
    write_reg(REG_KEY_HOLDOFF, 2);
    for (int i = 0; i < 200; i++) begin
      t = rand_tick(10);
      t.dur_s = 6'($urandom_range(0, 12));
      t.per_s = 4'($urandom_range(1, 6));
      send_tick(t);
    end
  endtask

  task automatic test_no_gaps();
    gaps_on = 1'b0;
    for (int i = 0; i < 80; i++) send_tick(rand_tick(30));
    gaps_on = 1'b1;
  endtask

  initial begin
    reset_model();
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    test_directed();
    wait_drained();
    test_fast_modes();
    wait_drained();
    test_long_periods();
    test_no_gaps();
    wait_drained();
    if (errors == 0) begin
      $display("tb: PASS");
    end else begin
      $display("tb: FAIL");
    end
    $finish;
  end
endmodule
`default_nettype wire
